// ----- hdl/count_up_seven_segment_scan_assert.svh -----
// Assertion macros for the count-up seven-segment scan block.
// Used by the checker module; depends on clk and rst in the including scope.
`ifndef COUNT_UP_SEVEN_SEGMENT_SCAN_ASSERT_SVH
`define COUNT_UP_SEVEN_SEGMENT_SCAN_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CUSSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cusss assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define CUSSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cusss assertion failed: next-cycle check");

`endif

// ----- hdl/cusss_pkg.sv -----
// Shared types, constants and functions of the count-up seven-segment scan block.
// No dependencies.
package cusss_pkg;

  localparam int NUM_DIGITS = 4;
  localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int DC_W = $clog2(NUM_DIGITS + 1);
  localparam int COUNT_W = 14;
  localparam int EN_W = 4;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam logic [3:0] RPV_RESET = 4'd5;
  localparam logic [7:0] SEG_BLANK = 8'hFF;

  function automatic int max_value_f();
    int m;
    m = 1;
    for (int i = 0; i < NUM_DIGITS && i < 4; i++) begin
      m = m * 10;
    end
    return m - 1;
  endfunction

  localparam logic [COUNT_W-1:0] MAX_VALUE = COUNT_W'(max_value_f());

  typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

  typedef struct packed {
    logic [EN_W-1:0]    digit_enable;
    logic [7:0]         segments;
    logic [COUNT_W-1:0] shown_value;
    logic [3:0]         slot_digit;
    logic               arrived;
  } result_t;

  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'hC0;
      4'd1: s = 8'hF9;
      4'd2: s = 8'hA4;
      4'd3: s = 8'hB0;
      4'd4: s = 8'h99;
      4'd5: s = 8'h92;
      4'd6: s = 8'h82;
      4'd7: s = 8'hD8;
      4'd8: s = 8'h80;
      4'd9: s = 8'h90;
      default: s = 8'hC0;
    endcase
    return s;
  endfunction

  function automatic logic [DC_W-1:0] digit_count_f(input digits_t d);
    logic [DC_W-1:0] n;
    n = DC_W'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (d[i] != 4'd0) begin
        n = DC_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

// ----- hdl/cusss_core.sv -----
// Count, BCD digits, scan position and round counter with the per-slot result logic.
// Depends on cusss_pkg.
module cusss_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic                            cmd,
  input  logic [cusss_pkg::COUNT_W-1:0]   target_value,
  input  logic                            cfg_we,
  input  logic [3:0]                      cfg_data,
  output cusss_pkg::result_t              result
);

  logic [3:0]                      rounds_per_value;
  logic [cusss_pkg::COUNT_W-1:0]   current_count;
  logic [cusss_pkg::COUNT_W-1:0]   target_store;
  cusss_pkg::digits_t              decimal_digits;
  logic [cusss_pkg::POS_W-1:0]     scan_position;
  logic [3:0]                      round_counter;
  logic                            holding;

  logic [cusss_pkg::COUNT_W-1:0]   current_count_next;
  logic [cusss_pkg::COUNT_W-1:0]   target_store_next;
  cusss_pkg::digits_t              decimal_digits_next;
  logic [cusss_pkg::POS_W-1:0]     scan_position_next;
  logic [3:0]                      round_counter_next;
  logic                            holding_next;

  logic [cusss_pkg::COUNT_W-1:0]   target_sat;
  logic [cusss_pkg::COUNT_W-1:0]   count_inc;
  cusss_pkg::digits_t              digits_inc;
  logic                            carry;
  logic [3:0]                      need;
  logic [3:0]                      round_inc;
  logic                            step_up;
  logic [cusss_pkg::DC_W-1:0]      dc_new;
  logic [3:0]                      dig;
  logic [cusss_pkg::NUM_DIGITS-1:0] en_wide;

  always_comb begin
    target_sat = (target_value > cusss_pkg::MAX_VALUE) ? cusss_pkg::MAX_VALUE : target_value;
    count_inc  = current_count + cusss_pkg::COUNT_W'(1);

    digits_inc = decimal_digits;
    carry = 1'b1;
    for (int i = 0; i < cusss_pkg::NUM_DIGITS; i++) begin
      if (carry) begin
        if (decimal_digits[i] == 4'd9) begin
          digits_inc[i] = 4'd0;
        end else begin
          digits_inc[i] = decimal_digits[i] + 4'd1;
          carry = 1'b0;
        end
      end
    end

    need      = (rounds_per_value == 4'd0) ? 4'd1 : rounds_per_value;
    round_inc = round_counter + 4'd1;
    step_up   = !holding && (round_inc >= need);

    dig = decimal_digits[scan_position];
    en_wide = '0;
    en_wide[scan_position] = 1'b1;

    result.digit_enable = '0;
    for (int i = 0; i < cusss_pkg::EN_W && i < cusss_pkg::NUM_DIGITS; i++) begin
      result.digit_enable[i] = en_wide[i];
    end
    result.segments    = cusss_pkg::seg_code(dig);
    result.shown_value = current_count;
    result.slot_digit  = dig;
    result.arrived     = holding;

    current_count_next  = current_count;
    target_store_next   = target_store;
    decimal_digits_next = decimal_digits;
    round_counter_next  = round_counter;
    holding_next        = holding;
    dc_new              = cusss_pkg::digit_count_f(decimal_digits);

    if (cmd == cusss_pkg::CMD_LOAD) begin
      target_store_next   = target_sat;
      current_count_next  = '0;
      decimal_digits_next = '0;
      round_counter_next  = 4'd0;
      holding_next        = (target_sat == '0);
      scan_position_next  = '0;
      result.digit_enable = '0;
      result.segments     = cusss_pkg::SEG_BLANK;
      result.shown_value  = '0;
      result.slot_digit   = 4'd0;
      result.arrived      = (target_sat == '0);
    end else if (scan_position == '0) begin
      if (!holding) begin
        round_counter_next = round_inc;
      end
      if (step_up) begin
        round_counter_next  = 4'd0;
        current_count_next  = count_inc;
        decimal_digits_next = digits_inc;
        dc_new              = cusss_pkg::digit_count_f(digits_inc);
        holding_next        = (count_inc >= target_store);
      end
      scan_position_next = cusss_pkg::POS_W'(dc_new - cusss_pkg::DC_W'(1));
    end else begin
      scan_position_next = scan_position - cusss_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rounds_per_value <= cusss_pkg::RPV_RESET;
    end else if (cfg_we) begin
      rounds_per_value <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_count  <= '0;
      target_store   <= '0;
      decimal_digits <= '0;
      scan_position  <= '0;
      round_counter  <= 4'd0;
      holding        <= 1'b1;
    end else if (accept) begin
      current_count  <= current_count_next;
      target_store   <= target_store_next;
      decimal_digits <= decimal_digits_next;
      scan_position  <= scan_position_next;
      round_counter  <= round_counter_next;
      holding        <= holding_next;
    end
  end

endmodule

// ----- hdl/cusss_out_buf.sv -----
// Two-entry result buffer that registers results and decouples input from output stall.
// Depends on cusss_pkg.
module cusss_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cusss_pkg::result_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output cusss_pkg::result_t out_data
);

  cusss_pkg::result_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hdl/count_up_seven_segment_scan.sv -----
// Top level of the count-up seven-segment scan block.
// Depends on cusss_pkg, cusss_core and cusss_out_buf.
//
// Each accepted transaction is either a tick, which drives one digit slot of a
// right-aligned multiplexed display, or a load, which sets a new target and
// restarts the count at zero with a blank result. The block accepts one
// transaction per clock cycle while in_stall is low. Its result is registered
// in the output buffer. The count, digit and scan update is one registered step.
// A two-entry output buffer lets a new transaction in while a finished result
// waits; in_stall rises only when both entries are held. The rounds register
// is written through the cfg channel, which is always ready, and should only
// be written while the block is idle.
module count_up_seven_segment_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cmd,
  input  logic [cusss_pkg::COUNT_W-1:0] target_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cusss_pkg::EN_W-1:0]    digit_enable,
  output logic [7:0]                    segments,
  output logic [cusss_pkg::COUNT_W-1:0] shown_value,
  output logic [3:0]                    slot_digit,
  output logic                          arrived,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [3:0]                    cfg_data
);

  logic               accept;
  logic               full;
  cusss_pkg::result_t result;
  cusss_pkg::result_t out_data;

  assign in_stall  = full;
  assign accept    = in_valid && !full;
  assign cfg_ready = 1'b1;

  cusss_core u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .cmd          (cmd),
    .target_value (target_value),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .result       (result)
  );

  cusss_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign digit_enable = out_data.digit_enable;
  assign segments     = out_data.segments;
  assign shown_value  = out_data.shown_value;
  assign slot_digit   = out_data.slot_digit;
  assign arrived      = out_data.arrived;

endmodule

// ----- hdl/cusss_checker.sv -----
// Port-level checker for the count-up seven-segment scan block, bound to the top level.
// Depends on cusss_pkg and count_up_seven_segment_scan_assert.svh.
`include "count_up_seven_segment_scan_assert.svh"

module cusss_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [cusss_pkg::EN_W-1:0]    digit_enable,
  input logic [7:0]                    segments,
  input logic [cusss_pkg::COUNT_W-1:0] shown_value,
  input logic [3:0]                    slot_digit,
  input logic                          arrived
);

  logic lit_ok;
  logic blank_ok;

  assign blank_ok = (segments == 8'hFF) && (shown_value == '0) && (slot_digit == 4'd0);
  assign lit_ok   = segments[7] && (slot_digit <= 4'd9) &&
                    (shown_value <= cusss_pkg::MAX_VALUE) &&
                    (!arrived || (shown_value != '0) || (slot_digit == 4'd0));

  `CUSSS_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)
  `CUSSS_ASSERT_NOW(a_enable_onehot, out_valid, $onehot0(digit_enable))
  `CUSSS_ASSERT_NOW(a_blank_load, out_valid && digit_enable == '0, blank_ok)
  `CUSSS_ASSERT_NOW(a_lit_slot, out_valid && digit_enable != '0, lit_ok)

endmodule

bind count_up_seven_segment_scan cusss_checker u_cusss_checker (.*);

// ----- verif/tb_count_up_seven_segment_scan.sv -----
// Self-checking testbench for count_up_seven_segment_scan: a directed table, then random
// tick and load traffic with sender gaps and receiver stalls, checked against a scan model.
// Depends on cusss_pkg and the RTL of the block; reads no files.
module tb_count_up_seven_segment_scan;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DISPLAY_MAX = 9999;
  localparam int TOTAL_ITEMS = 1300;
  localparam int NUM_PHASES = 6;
  localparam int TABLE_ROWS = 20;
  localparam logic [9:0][7:0] SEG_ROM = {8'h90, 8'h80, 8'hD8, 8'h82, 8'h92,
                                         8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};

  localparam cusss_pkg::result_t ZERO_HELD = '{4'b0001, 8'hC0, 14'd0, 4'd0, 1'b1};
  localparam cusss_pkg::result_t ZERO_OPEN = '{4'b0001, 8'hC0, 14'd0, 4'd0, 1'b0};
  localparam cusss_pkg::result_t BLANK_HELD =
    '{4'b0000, cusss_pkg::SEG_BLANK, 14'd0, 4'd0, 1'b1};
  localparam cusss_pkg::result_t BLANK_OPEN =
    '{4'b0000, cusss_pkg::SEG_BLANK, 14'd0, 4'd0, 1'b0};
  localparam cusss_pkg::result_t NOT_TYPED = '0;

  typedef struct packed {
    logic               cmd;
    logic [13:0]        target;
    logic               typed;
    cusss_pkg::result_t res;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          cmd = cusss_pkg::CMD_TICK;
  logic [cusss_pkg::COUNT_W-1:0] target_value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [cusss_pkg::EN_W-1:0]    digit_enable;
  logic [7:0]                    segments;
  logic [cusss_pkg::COUNT_W-1:0] shown_value;
  logic [3:0]                    slot_digit;
  logic                          arrived;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [3:0]                    cfg_data = '0;

  logic [3:0]  rounds_setting = cusss_pkg::RPV_RESET;
  int unsigned disp_count = 0;
  int unsigned disp_target = 0;
  logic [3:0]  disp_digits [cusss_pkg::NUM_DIGITS];
  int unsigned disp_ndigits = 1;
  int unsigned disp_pos = 0;
  int unsigned disp_round = 0;
  bit          disp_hold = 1'b1;

  cusss_pkg::result_t pending_frames [$];
  int unsigned sent_items = 0;
  int unsigned error_count = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  int          stall_left = 0;

  stim_row_t   stim_rows [TABLE_ROWS];
  logic [3:0]  phase_rounds [NUM_PHASES];

  count_up_seven_segment_scan dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .target_value (target_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digit_enable (digit_enable),
    .segments     (segments),
    .shown_value  (shown_value),
    .slot_digit   (slot_digit),
    .arrived      (arrived),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void split_count();
    int unsigned v;
    v = disp_count;
    disp_ndigits = 1;
    for (int i = 0; i < cusss_pkg::NUM_DIGITS; i++) begin
      disp_digits[i] = 4'(v % 10);
      v = v / 10;
      if (disp_digits[i] != 4'd0) disp_ndigits = i + 1;
    end
  endfunction

  function automatic cusss_pkg::result_t predict_display_step(logic c, logic [13:0] tv);
    cusss_pkg::result_t r;
    int unsigned        need;
    logic [3:0]         d;
    if (c == cusss_pkg::CMD_LOAD) begin
      disp_target = (tv > DISPLAY_MAX) ? DISPLAY_MAX : tv;
      disp_count = 0;
      split_count();
      disp_pos = 0;
      disp_round = 0;
      disp_hold = (disp_target == 0);
      r = disp_hold ? BLANK_HELD : BLANK_OPEN;
      return r;
    end
    d = disp_digits[disp_pos];
    r.digit_enable = cusss_pkg::EN_W'(1) << disp_pos;
    r.segments = SEG_ROM[d];
    r.shown_value = cusss_pkg::COUNT_W'(disp_count);
    r.slot_digit = d;
    r.arrived = disp_hold;
    if (disp_pos == 0) begin
      if (!disp_hold) begin
        need = (rounds_setting == 4'd0) ? 1 : rounds_setting;
        disp_round = (disp_round + 1) & 4'hF;
        if (disp_round >= need) begin
          disp_round = 0;
          disp_count++;
          split_count();
          if (disp_count >= disp_target) disp_hold = 1'b1;
        end
      end
      disp_pos = disp_ndigits - 1;
    end else begin
      disp_pos = disp_pos - 1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic send_item(logic c, logic [13:0] tv, logic typed, cusss_pkg::result_t known);
    int                 gap;
    cusss_pkg::result_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    cmd <= c;
    target_value <= tv;
    do @(posedge clk); while (in_stall);
    r = predict_display_step(c, tv);
    pending_frames.push_back(typed ? known : r);
    sent_items++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_rounds(logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rounds_setting = v;
  endtask

  task automatic run_phase(int quota);
    int unsigned done_at;
    int          eff;
    int          lim;
    int          t;
    int          n;
    int          left;
    int          kind;
    done_at = sent_items + quota;
    eff = (rounds_setting == 4'd0) ? 1 : rounds_setting;
    while (sent_items < done_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        lim = (eff <= 2) ? 130 : (eff <= 5) ? 30 : 8;
        t = $urandom_range(0, lim);
        send_item(cusss_pkg::CMD_LOAD, 14'(t), 1'b0, NOT_TYPED);
        n = $urandom_range(1, t * eff * 2 + 40);
        if (n > 350) n = 350;
        left = int'(done_at - sent_items);
        if (n > left) n = left;
        repeat (n) send_item(cusss_pkg::CMD_TICK, 14'($urandom), 1'b0, NOT_TYPED);
      end else if (kind < 90) begin
        send_item(cusss_pkg::CMD_LOAD, 14'($urandom_range(0, 16383)), 1'b0, NOT_TYPED);
        n = $urandom_range(1, 30);
        left = int'(done_at - sent_items);
        if (n > left) n = left;
        repeat (n) send_item(cusss_pkg::CMD_TICK, 14'($urandom), 1'b0, NOT_TYPED);
      end else begin
        n = $urandom_range(1, 6);
        left = int'(done_at - sent_items);
        if (n > left) n = left;
        repeat (n)
          send_item($urandom_range(0, 1) ? cusss_pkg::CMD_LOAD : cusss_pkg::CMD_TICK,
                    14'($urandom), 1'b0, NOT_TYPED);
      end
      if ($urandom_range(0, 24) == 0) wait_idle();
    end
  endtask

  always @(posedge clk) begin : stall_pattern
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(40, 300);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((stall_left % 5) < 2);
    endcase
  end

  always @(posedge clk) begin : result_check
    cusss_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, shown_value %0d", shown_value));
      end else begin
        want = pending_frames.pop_front();
        if (digit_enable !== want.digit_enable)
          report_mismatch($sformatf("digit_enable %b, expected %b", digit_enable,
                                    want.digit_enable));
        if (segments !== want.segments)
          report_mismatch($sformatf("segments %h, expected %h", segments, want.segments));
        if (shown_value !== want.shown_value)
          report_mismatch($sformatf("shown_value %0d, expected %0d", shown_value,
                                    want.shown_value));
        if (slot_digit !== want.slot_digit)
          report_mismatch($sformatf("slot_digit %0d, expected %0d", slot_digit,
                                    want.slot_digit));
        if (arrived !== want.arrived)
          report_mismatch($sformatf("arrived %b, expected %b", arrived, want.arrived));
      end
    end
  end

  initial begin : stimulus
    for (int i = 0; i < cusss_pkg::NUM_DIGITS; i++) disp_digits[i] = 4'd0;
    stim_rows[0] = '{cusss_pkg::CMD_TICK, 14'd0, 1'b1, ZERO_HELD};
    stim_rows[1] = '{cusss_pkg::CMD_TICK, 14'd16383, 1'b1, ZERO_HELD};
    stim_rows[2] = '{cusss_pkg::CMD_LOAD, 14'd0, 1'b1, BLANK_HELD};
    stim_rows[3] = '{cusss_pkg::CMD_LOAD, 14'd16383, 1'b1, BLANK_OPEN};
    stim_rows[4] = '{cusss_pkg::CMD_LOAD, 14'd10000, 1'b1, BLANK_OPEN};
    stim_rows[5] = '{cusss_pkg::CMD_LOAD, 14'd9999, 1'b1, BLANK_OPEN};
    stim_rows[6] = '{cusss_pkg::CMD_TICK, 14'h2AAA, 1'b1, ZERO_OPEN};
    stim_rows[7] = '{cusss_pkg::CMD_LOAD, 14'd2, 1'b1, BLANK_OPEN};
    for (int i = 8; i < TABLE_ROWS; i++)
      stim_rows[i] = '{cusss_pkg::CMD_TICK, (i % 2) ? 14'h1555 : 14'h2AAA, 1'b0, NOT_TYPED};
    phase_rounds = '{4'd0, 4'd1, 4'd15, 4'd2, 4'd1, 4'd7};
    phase_rounds[NUM_PHASES-1] = 4'($urandom_range(3, 14));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < TABLE_ROWS; i++)
      send_item(stim_rows[i].cmd, stim_rows[i].target, stim_rows[i].typed, stim_rows[i].res);
    wait_idle();
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_rounds(phase_rounds[p]);
      run_phase(TOTAL_ITEMS / NUM_PHASES);
      wait_idle();
    end
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
